### design/beg_pkg.sv
`timescale 1ns / 1ps

package beg_pkg;

    localparam int MAX_POINTS = 16;
    localparam int PTR_W      = 4;
    localparam int VAL_W      = 32;
    localparam int TIME_W     = 32;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_W      = 32;
    localparam int NPTS_W     = 5;
    localparam int DIV_STEPS  = 64;
    localparam int DCNT_W     = 6;

    localparam logic signed [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] STEP_RESET = 32'h0001_0000;
    localparam logic [NPTS_W-1:0] NPTS_RESET = 5'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS    = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_TICK    = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_PREP,
        S_LVL_GO,
        S_LVL_WAIT,
        S_SLP_GO,
        S_SLP_WAIT,
        S_DONE
    } t_state;

    typedef enum logic {
        DV_IDLE,
        DV_RUN
    } t_div_state;

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  a;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] d;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [VAL_W-1:0]  q;
    } t_div_res;

    function automatic logic signed [VAL_W-1:0] clamp_val(input logic signed [VAL_W:0] x);
        logic signed [VAL_W-1:0] res;
        if (x[VAL_W] != x[VAL_W-1]) begin
            res = x[VAL_W] ? VMIN : VMAX;
        end else begin
            res = x[VAL_W-1:0];
        end
        return res;
    endfunction

    // apply the sign to a magnitude quotient, saturating at the value range
    function automatic logic signed [VAL_W-1:0] signed_q(input logic neg, input logic sat,
                                                         input logic [VAL_W-1:0] q);
        logic signed [VAL_W-1:0] res;
        if (sat) begin
            res = neg ? VMIN : VMAX;
        end else if (neg) begin
            res = -$signed(q);
        end else begin
            res = $signed(q);
        end
        return res;
    endfunction

endpackage

### design/beg_muldiv.sv
`timescale 1ns / 1ps

module beg_muldiv (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  beg_pkg::t_div_req i_req,
    output beg_pkg::t_div_res o_res
);

    beg_pkg::t_div_state r_state, n_state;

    logic [2*beg_pkg::VAL_W-1:0]  r_prod;
    logic [beg_pkg::TIME_W-1:0]   r_rem;
    logic [beg_pkg::TIME_W-1:0]   r_d;
    logic [beg_pkg::VAL_W-1:0]    r_q;
    logic                         r_over;
    logic [beg_pkg::DCNT_W-1:0]   r_cnt;
    logic                         r_done;

    logic [2*beg_pkg::VAL_W-1:0]  w_prod;
    logic [beg_pkg::TIME_W:0]     w_rem_sh;
    logic [beg_pkg::TIME_W:0]     w_diff;
    logic                         w_ge;
    logic                         w_last;

    assign w_prod   = i_req.a * i_req.b;
    assign w_rem_sh = {r_rem, r_prod[2*beg_pkg::VAL_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_d};
    assign w_ge     = (w_rem_sh >= {1'b0, r_d});
    assign w_last   = (r_cnt == beg_pkg::DCNT_W'(beg_pkg::DIV_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            beg_pkg::DV_IDLE: begin
                if (i_req.start) n_state = beg_pkg::DV_RUN;
            end
            beg_pkg::DV_RUN: begin
                if (w_last) n_state = beg_pkg::DV_IDLE;
            end
            default: n_state = beg_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= beg_pkg::DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == beg_pkg::DV_RUN) && w_last;
        end
    end

    // one quotient bit per cycle; bits pushed out of the top make the result saturate
    always_ff @(posedge i_clk) begin
        if (r_state == beg_pkg::DV_IDLE) begin
            if (i_req.start) begin
                r_prod <= w_prod;
                r_d    <= i_req.d;
                r_rem  <= '0;
                r_q    <= '0;
                r_over <= 1'b0;
                r_cnt  <= '0;
            end
        end else begin
            r_rem  <= w_ge ? w_diff[beg_pkg::TIME_W-1:0] : w_rem_sh[beg_pkg::TIME_W-1:0];
            r_prod <= {r_prod[2*beg_pkg::VAL_W-2:0], 1'b0};
            r_q    <= {r_q[beg_pkg::VAL_W-2:0], w_ge};
            r_over <= r_over | r_q[beg_pkg::VAL_W-1];
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    assign o_res.done = r_done;
    assign o_res.sat  = r_over | r_q[beg_pkg::VAL_W-1];
    assign o_res.q    = r_q;

endmodule

### design/breakpoint_envelope_generator_unit.sv
`timescale 1ns / 1ps

// Piecewise-linear breakpoint envelope in Q16.16. A load beat writes one slot of the
// 16-entry breakpoint table, a restart sets time to zero and locates the segment, a tick
// advances time by time_step and adds the per-tick increment to the level. Every input
// beat yields exactly one output beat with the level, the done flag and the segment.
// The input is taken only while the sequencer is idle. A load or an unused op goes
// straight to the done state, a tick that stays inside its segment passes the tick
// check only, a segment change without interpolation (before the first or from the
// last point) stops at the first or last point check, and a segment change with
// interpolation goes on: the table is scanned one entry a cycle through a registered
// read port, then one shared 32x32 multiplier and 64-step shift-subtract divider runs
// twice, once for the level and once for the increment. A result that finds the
// output register still full waits in the done state until the sink takes the previous
// beat. The output beat sits in its own register, so a stalled sink does not hold up
// the next input beat until that beat's result is ready.

module breakpoint_envelope_generator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // point_index[3:0], point_time[35:4], point_value[67:36]
    input  logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // level[31:0], segment[35:32]
    output logic        o_m_axis_tuser,   // done_res[0]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int VW = beg_pkg::VAL_W;
    localparam int TW = beg_pkg::TIME_W;
    localparam int PW = beg_pkg::PTR_W;

    beg_pkg::t_state r_state, n_state;

    // breakpoint table
    logic [TW-1:0]        r_bp_times  [beg_pkg::MAX_POINTS];
    logic signed [VW-1:0] r_bp_levels [beg_pkg::MAX_POINTS];
    logic [TW-1:0]        r_trd;
    logic signed [VW-1:0] r_vrd;

    // envelope state and configuration
    logic [TW-1:0]        r_now;
    logic signed [VW-1:0] r_level;
    logic signed [VW-1:0] r_slope;
    logic [TW-1:0]        r_next;
    logic                 r_hold;
    logic [PW-1:0]        r_seg;
    logic [TW-1:0]        r_step;
    logic [beg_pkg::NPTS_W-1:0] r_npts;

    // search and interpolation scratch
    logic [PW-1:0]        r_idx;
    logic [TW-1:0]        r_prev_t;
    logic signed [VW-1:0] r_prev_v;
    logic [TW-1:0]        r_tlo;
    logic [TW-1:0]        r_thi;
    logic signed [VW-1:0] r_vlo;
    logic signed [VW-1:0] r_vhi;
    logic [PW-1:0]        r_segn;
    logic                 r_neg;
    logic [VW-1:0]        r_mag;
    logic [TW-1:0]        r_dt;
    logic [TW-1:0]        r_span;
    logic signed [VW-1:0] r_lvl_new;

    // output register
    logic                 r_out_valid;
    logic signed [VW-1:0] r_out_level;
    logic                 r_out_done;
    logic [PW-1:0]        r_out_seg;

    logic                 w_in_acc;
    beg_pkg::t_op         w_op;
    logic [PW-1:0]        w_pidx;
    logic [TW-1:0]        w_ptime;
    logic signed [VW-1:0] w_pval;
    logic [PW-1:0]        w_last;
    logic [PW-1:0]        w_rd_addr;
    logic [TW:0]          w_now_sum;
    logic [TW-1:0]        w_now_sat;
    logic signed [VW-1:0] w_lvl_tick;
    logic                 w_found;
    logic                 w_scan_end;
    logic signed [VW:0]   w_dv;
    logic [VW:0]          w_mag;
    logic signed [VW-1:0] w_sq;
    logic                 w_out_free;
    beg_pkg::t_div_req    w_div_req;
    beg_pkg::t_div_res    w_div_res;

    assign w_in_acc = i_s_axis_tvalid && (r_state == beg_pkg::S_IDLE);
    assign w_op     = beg_pkg::t_op'(i_s_axis_tuser);
    assign w_pidx   = i_s_axis_tdata[3:0];
    assign w_ptime  = i_s_axis_tdata[35:4];
    assign w_pval   = $signed(i_s_axis_tdata[67:36]);

    // a count of zero acts as one, above the table size as the table size
    always_comb begin
        priority if (r_npts == '0) begin
            w_last = '0;
        end else if (r_npts > beg_pkg::NPTS_W'(beg_pkg::MAX_POINTS)) begin
            w_last = PW'(beg_pkg::MAX_POINTS - 1);
        end else begin
            w_last = PW'(r_npts - 1'b1);
        end
    end

    assign w_now_sum  = {1'b0, r_now} + {1'b0, r_step};
    assign w_now_sat  = w_now_sum[TW] ? beg_pkg::TIME_MAX : w_now_sum[TW-1:0];
    assign w_lvl_tick = beg_pkg::clamp_val({r_level[VW-1], r_level} + {r_slope[VW-1], r_slope});

    assign w_found    = (r_prev_t <= r_now) && (r_trd > r_now);
    assign w_scan_end = (r_idx == w_last);

    assign w_dv  = {r_vhi[VW-1], r_vhi} - {r_vlo[VW-1], r_vlo};
    assign w_mag = w_dv[VW] ? -w_dv : w_dv;
    assign w_sq  = beg_pkg::signed_q(r_neg, w_div_res.sat, w_div_res.q);

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // table read address, data shows up in the next cycle
    always_comb begin
        unique case (r_state)
            beg_pkg::S_CHK_FIRST: w_rd_addr = w_last;
            beg_pkg::S_CHK_LAST:  w_rd_addr = PW'(1);
            beg_pkg::S_SCAN:      w_rd_addr = r_idx + 1'b1;
            default:              w_rd_addr = '0;
        endcase
    end

    assign w_div_req.start = (r_state == beg_pkg::S_LVL_GO) || (r_state == beg_pkg::S_SLP_GO);
    assign w_div_req.a     = r_mag;
    assign w_div_req.b     = (r_state == beg_pkg::S_SLP_GO) ? r_step : r_dt;
    assign w_div_req.d     = r_span;

    beg_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_res   (w_div_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            beg_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_op)
                        beg_pkg::OP_RESTART: n_state = beg_pkg::S_CHK_FIRST;
                        beg_pkg::OP_TICK:    n_state = beg_pkg::S_TICK;
                        default:             n_state = beg_pkg::S_DONE;
                    endcase
                end
            end
            beg_pkg::S_TICK: begin
                n_state = (!r_hold && (r_now >= r_next)) ? beg_pkg::S_CHK_FIRST
                                                         : beg_pkg::S_DONE;
            end
            beg_pkg::S_CHK_FIRST: begin
                n_state = (r_now < r_trd) ? beg_pkg::S_DONE : beg_pkg::S_CHK_LAST;
            end
            beg_pkg::S_CHK_LAST: begin
                n_state = (r_now >= r_trd) ? beg_pkg::S_DONE : beg_pkg::S_SCAN;
            end
            beg_pkg::S_SCAN: begin
                priority if (w_found) begin
                    n_state = beg_pkg::S_PREP;
                end else if (w_scan_end) begin
                    n_state = beg_pkg::S_DONE;
                end
            end
            beg_pkg::S_PREP:     n_state = beg_pkg::S_LVL_GO;
            beg_pkg::S_LVL_GO:   n_state = beg_pkg::S_LVL_WAIT;
            beg_pkg::S_LVL_WAIT: begin
                if (w_div_res.done) n_state = beg_pkg::S_SLP_GO;
            end
            beg_pkg::S_SLP_GO:   n_state = beg_pkg::S_SLP_WAIT;
            beg_pkg::S_SLP_WAIT: begin
                if (w_div_res.done) n_state = beg_pkg::S_DONE;
            end
            beg_pkg::S_DONE: begin
                if (w_out_free) n_state = beg_pkg::S_IDLE;
            end
            default: n_state = beg_pkg::S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == beg_pkg::S_IDLE);
    assign o_cfg_ready     = 1'b1;

    // control and envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= beg_pkg::S_IDLE;
            r_now       <= '0;
            r_level     <= '0;
            r_slope     <= '0;
            r_next      <= '0;
            r_hold      <= 1'b0;
            r_seg       <= '0;
            r_step      <= beg_pkg::STEP_RESET;
            r_npts      <= beg_pkg::NPTS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    beg_pkg::CFG_TIME_STEP: r_step <= i_cfg_data;
                    beg_pkg::CFG_POINTS:    r_npts <= i_cfg_data[beg_pkg::NPTS_W-1:0];
                    default:                r_step <= r_step;
                endcase
            end

            if (w_in_acc && (w_op == beg_pkg::OP_RESTART)) begin
                r_now <= '0;
            end else if (w_in_acc && (w_op == beg_pkg::OP_TICK)) begin
                r_now   <= w_now_sat;
                r_level <= w_lvl_tick;
            end

            // before the first point hold its value, from the last point on hold and flag
            if ((r_state == beg_pkg::S_CHK_FIRST) && (r_now < r_trd)) begin
                r_level <= r_vrd;
                r_next  <= r_trd;
                r_slope <= '0;
                r_hold  <= 1'b0;
                r_seg   <= '0;
            end
            if ((r_state == beg_pkg::S_CHK_LAST) && (r_now >= r_trd)) begin
                r_level <= r_vrd;
                r_next  <= beg_pkg::TIME_MAX;
                r_slope <= '0;
                r_hold  <= 1'b1;
                r_seg   <= w_last;
            end
            if ((r_state == beg_pkg::S_SLP_WAIT) && w_div_res.done) begin
                r_level <= r_lvl_new;
                r_slope <= w_sq;
                r_next  <= r_thi;
                r_hold  <= 1'b0;
                r_seg   <= r_segn;
            end

            if ((r_state == beg_pkg::S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_op == beg_pkg::OP_LOAD)) begin
            r_bp_times[w_pidx]  <= w_ptime;
            r_bp_levels[w_pidx] <= w_pval;
        end
        r_trd <= r_bp_times[w_rd_addr];
        r_vrd <= r_bp_levels[w_rd_addr];
    end

    // search and interpolation datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            beg_pkg::S_CHK_FIRST: begin
                r_prev_t <= r_trd;
                r_prev_v <= r_vrd;
            end
            beg_pkg::S_CHK_LAST: begin
                r_idx <= PW'(1);
            end
            beg_pkg::S_SCAN: begin
                if (w_found) begin
                    r_tlo  <= r_prev_t;
                    r_vlo  <= r_prev_v;
                    r_thi  <= r_trd;
                    r_vhi  <= r_vrd;
                    r_segn <= r_idx - 1'b1;
                end else begin
                    r_prev_t <= r_trd;
                    r_prev_v <= r_vrd;
                    r_idx    <= r_idx + 1'b1;
                end
            end
            beg_pkg::S_PREP: begin
                r_neg  <= w_dv[VW];
                r_mag  <= w_mag[VW-1:0];
                r_dt   <= r_now - r_tlo;
                r_span <= r_thi - r_tlo;
            end
            beg_pkg::S_LVL_WAIT: begin
                if (w_div_res.done) begin
                    r_lvl_new <= beg_pkg::clamp_val({r_vlo[VW-1], r_vlo} + {w_sq[VW-1], w_sq});
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if ((r_state == beg_pkg::S_DONE) && w_out_free) begin
            r_out_level <= r_level;
            r_out_done  <= r_hold;
            r_out_seg   <= r_seg;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0, r_out_seg, r_out_level};
    assign o_m_axis_tuser  = r_out_done;

endmodule

### verif/envelope_checker.sv
`timescale 1ns / 1ps

module envelope_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [71:0] i_s_tdata,   // point_index[3:0], point_time[35:4], point_value[67:36]
    input  logic [1:0]  i_s_tuser,   // op[1:0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // level[31:0], segment[35:32]
    input  logic        i_m_tuser,   // done_res[0]
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_done_seen
);

    localparam int VW = beg_pkg::VAL_W;
    localparam int TW = beg_pkg::TIME_W;
    localparam int PW = beg_pkg::PTR_W;
    localparam int NP = beg_pkg::MAX_POINTS;

    localparam logic [63:0] QUOT_CAP = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [VW-1:0] level;
        logic                 done;
        logic [PW-1:0]        seg;
    } t_env_out;

    t_env_out outputs_due[$];

    // shadow of the envelope state
    logic [TW-1:0]        bp_t [NP];
    logic signed [VW-1:0] bp_v [NP];
    logic [TW-1:0]        t_now;
    logic [TW-1:0]        nxt_break;
    logic signed [VW-1:0] acc;
    logic signed [VW-1:0] incr;
    logic                 hold;
    logic [PW-1:0]        seg;
    logic [TW-1:0]        step_cfg;
    logic [beg_pkg::NPTS_W-1:0] pts_cfg;

    int fails;
    int checked;
    int done_seen;

    function automatic logic signed [VW-1:0] sat_sum(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
        logic [VW:0] s;
        logic signed [VW-1:0] r;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1]) begin
            r = s[VW] ? beg_pkg::VMIN : beg_pkg::VMAX;
        end else begin
            r = s[VW-1:0];
        end
        return r;
    endfunction

    // floor(mag * mult / span), capped
    function automatic logic [63:0] scaled_quot(input logic [31:0] mag, input logic [31:0] mult,
                                                input logic [31:0] span);
        logic [63:0] prod;
        logic [63:0] q;
        prod = {32'd0, mag} * {32'd0, mult};
        q = (span == '0) ? QUOT_CAP : prod / {32'd0, span};
        return (q > QUOT_CAP) ? QUOT_CAP : q;
    endfunction

    function automatic logic signed [VW-1:0] apply_sign(input logic neg, input logic [63:0] q);
        logic signed [VW-1:0] r;
        if (neg) begin
            r = (q > 64'h8000_0000) ? beg_pkg::VMIN : -$signed(q[31:0]);
        end else begin
            r = (q > 64'h7FFF_FFFF) ? beg_pkg::VMAX : $signed(q[31:0]);
        end
        return r;
    endfunction

    function automatic void locate_segment();
        int n;
        int i;
        logic found;
        logic [31:0] span;
        logic [31:0] dt;
        logic signed [32:0] dv;
        logic [32:0] mag;
        logic neg;
        n = (pts_cfg == 0) ? 1 : (pts_cfg > NP) ? NP : int'(pts_cfg);
        if (t_now < bp_t[0]) begin
            acc       = bp_v[0];
            nxt_break = bp_t[0];
            incr      = '0;
            hold      = 1'b0;
            seg       = '0;
        end else if (t_now >= bp_t[n-1]) begin
            acc       = bp_v[n-1];
            nxt_break = beg_pkg::TIME_MAX;
            incr      = '0;
            hold      = 1'b1;
            seg       = PW'(n - 1);
        end else begin
            // a table out of order can leave no bracketing pair: state stays as it is
            found = 1'b0;
            for (i = 0; i + 1 < n; i++) begin
                if (!found && bp_t[i] <= t_now && bp_t[i+1] > t_now) begin
                    found = 1'b1;
                    span  = bp_t[i+1] - bp_t[i];
                    dt    = t_now - bp_t[i];
                    dv    = $signed({bp_v[i+1][VW-1], bp_v[i+1]})
                          - $signed({bp_v[i][VW-1], bp_v[i]});
                    neg   = dv[32];
                    mag   = neg ? -dv : dv;
                    acc   = sat_sum(bp_v[i], apply_sign(neg, scaled_quot(mag[31:0], dt, span)));
                    incr  = apply_sign(neg, scaled_quot(mag[31:0], step_cfg, span));
                    nxt_break = bp_t[i+1];
                    hold  = 1'b0;
                    seg   = PW'(i);
                end
            end
        end
    endfunction

    function automatic void apply_beat(input beg_pkg::t_op op, input logic [PW-1:0] idx,
                                       input logic [TW-1:0] pt, input logic [VW-1:0] pv);
        logic [TW:0] sum;
        case (op)
            beg_pkg::OP_LOAD: begin
                bp_t[idx] = pt;
                bp_v[idx] = pv;
            end
            beg_pkg::OP_RESTART: begin
                t_now = '0;
                locate_segment();
            end
            beg_pkg::OP_TICK: begin
                sum   = {1'b0, t_now} + {1'b0, step_cfg};
                t_now = sum[TW] ? beg_pkg::TIME_MAX : sum[TW-1:0];
                acc   = sat_sum(acc, incr);
                if (!hold && t_now >= nxt_break) begin
                    locate_segment();
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_env_out got;
        t_env_out want;
        if (!i_rst_n) begin
            for (int k = 0; k < NP; k++) begin
                bp_t[k] = '0;
                bp_v[k] = '0;
            end
            t_now     = '0;
            nxt_break = '0;
            acc       = '0;
            incr      = '0;
            hold      = 1'b0;
            seg       = '0;
            step_cfg  = beg_pkg::STEP_RESET;
            pts_cfg   = beg_pkg::NPTS_RESET;
            fails     = 0;
            checked   = 0;
            done_seen = 0;
            outputs_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == beg_pkg::CFG_TIME_STEP) begin
                    step_cfg = i_cfg_data;
                end else begin
                    pts_cfg = i_cfg_data[beg_pkg::NPTS_W-1:0];
                end
            end
            // results leave before the beat of this edge can have produced one
            if (i_m_tvalid && i_m_tready) begin
                got.level = i_m_tdata[31:0];
                got.seg   = i_m_tdata[35:32];
                got.done  = i_m_tuser;
                if (outputs_due.size() == 0) begin
                    fails++;
                    $display("%0t: expected no result beat, got level %h done %b segment %0d",
                             $time, got.level, got.done, got.seg);
                end else begin
                    want = outputs_due.pop_front();
                    checked++;
                    if (got.done) begin
                        done_seen++;
                    end
                    if (got.level !== want.level) begin
                        fails++;
                        $display("%0t: level expected %h, got %h",
                                 $time, want.level, got.level);
                    end
                    if (got.done !== want.done) begin
                        fails++;
                        $display("%0t: done expected %b, got %b", $time, want.done, got.done);
                    end
                    if (got.seg !== want.seg) begin
                        fails++;
                        $display("%0t: segment expected %0d, got %0d",
                                 $time, want.seg, got.seg);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_beat(beg_pkg::t_op'(i_s_tuser), i_s_tdata[3:0], i_s_tdata[35:4],
                           i_s_tdata[67:36]);
                want.level = acc;
                want.done  = hold;
                want.seg   = seg;
                outputs_due.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= outputs_due.size();
        o_checked    <= checked;
        o_done_seen  <= done_seen;
    end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_GOAL   = 920;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int done_seen;

    int beats_sent;
    int reg_writes;
    int phase;
    int hold_token;
    logic no_idle;

    breakpoint_envelope_generator_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    envelope_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_done_seen  (done_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // tvalid is left high after a beat; wait_results lowers it
    task automatic send_beat(input beg_pkg::t_op op, input logic [3:0] idx,
                             input logic [31:0] pt, input logic [31:0] pv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, pv, pt, idx};
        s_tuser  <= op;
        do @(posedge i_clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic wait_results();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // which: 0 both registers, 1 time step only, 2 point count only
    task automatic write_regs(input logic [31:0] step, input logic [4:0] npts, input int which);
        if (which != 2) begin
            cfg_index <= beg_pkg::CFG_TIME_STEP;
            cfg_data  <= step;
            cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ready);
            reg_writes++;
        end
        if (which != 1) begin
            cfg_index <= beg_pkg::CFG_POINTS;
            cfg_data  <= {27'd0, npts};
            cfg_valid <= 1'b1;
            do @(posedge i_clk); while (!cfg_ready);
            reg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_level();
        int r;
        logic [31:0] v;
        r = $urandom_range(0, 9);
        case (r)
            0:       v = beg_pkg::VMAX;
            1:       v = beg_pkg::VMIN;
            2:       v = '0;
            3, 4, 5: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // receiver: random stall per beat, one long hold on request
    initial begin
        int stall;
        int holds_taken;
        holds_taken = 0;
        m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_token != holds_taken) begin
                holds_taken++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 9);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n_eff;
        int ticks;
        int span_bits;
        int which;
        int r;
        int k;
        logic [4:0]  npts;
        logic [31:0] step;
        logic [31:0] t_acc;
        logic [31:0] horizon;
        logic [31:0] pt_time [16];
        logic [31:0] pt_level [16];

        beats_sent = 0;
        reg_writes = 0;
        phase      = 0;
        i_rst_n    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= beg_pkg::OP_LOAD;
        cfg_valid  <= 1'b0;
        cfg_index  <= beg_pkg::CFG_TIME_STEP;
        cfg_data   <= '0;
        hold_token <= 0;
        no_idle    <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill every slot, the last time at full scale, levels max, min, zero and random
        for (k = 0; k < 16; k++) begin
            case (k % 4)
                0:       pt_level[k] = beg_pkg::VMAX;
                1:       pt_level[k] = beg_pkg::VMIN;
                2:       pt_level[k] = '0;
                default: pt_level[k] = $urandom;
            endcase
            send_beat(beg_pkg::OP_LOAD, 4'(k), (k == 15) ? beg_pkg::TIME_MAX : 32'(k) << 17,
                      pt_level[k]);
        end
        // tick with the reset state, unused op, then restart with one point
        send_beat(beg_pkg::OP_TICK, 4'hF, '1, '1);
        send_beat(beg_pkg::OP_NONE, 4'hF, '1, '1);
        send_beat(beg_pkg::OP_RESTART, '0, '0, '0);
        send_beat(beg_pkg::OP_TICK, '0, '0, '0);
        wait_results();
        // full table, half step: the first segment swings from max to min
        write_regs(32'h0000_8000, 5'd16, 0);
        send_beat(beg_pkg::OP_RESTART, '0, '0, '0);
        for (k = 0; k < 5; k++) begin
            send_beat(beg_pkg::OP_TICK, 4'($urandom), $urandom, $urandom);
        end

        while (beats_sent < ITEM_GOAL) begin
            wait_results();
            phase++;
            no_idle <= ($urandom_range(0, 3) == 0);
            if (phase == 3) begin
                hold_token <= hold_token + 1;
            end

            if (phase % 9 == 2) begin
                npts = 5'd0;
            end else if (phase % 9 == 7) begin
                npts = 5'd31;
            end else if (phase % 13 == 5) begin
                npts = 5'd1;
            end else begin
                npts = 5'($urandom_range(2, 16));
            end
            n_eff = (npts == 0) ? 1 : (npts > 16) ? 16 : int'(npts);

            if ($urandom_range(0, 9) < 8) begin
                // ascending table with random content
                t_acc     = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h4000_0000);
                span_bits = $urandom_range(4, 26);
                for (k = 0; k < n_eff; k++) begin
                    pt_time[k]  = t_acc;
                    pt_level[k] = pick_level();
                    t_acc       = t_acc + $urandom_range(1, 1 << span_bits);
                end
                if (n_eff > 1 && $urandom_range(0, 4) == 0) begin
                    pt_time[n_eff-1] = beg_pkg::TIME_MAX;
                end
                horizon = (n_eff > 1 && pt_time[n_eff-1] == beg_pkg::TIME_MAX)
                        ? pt_time[n_eff-2] : pt_time[n_eff-1];
                if (horizon == 0) begin
                    horizon = 32'd16;
                end
                step = horizon / $urandom_range(3, 24) + $urandom_range(1, 8);
                if (phase % 7 == 1) begin
                    step = '1;
                end else if (phase % 7 == 4) begin
                    step = 32'd1;
                end else if (phase % 11 == 6) begin
                    step = '0;
                end
                ticks = (step == 0) ? 8 : int'(horizon / step) + 3;
                if (ticks > 40) begin
                    ticks = 40;
                end
                which = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
                if (phase % 7 == 1 || phase % 7 == 4 || phase % 11 == 6 || phase % 9 == 2
                        || phase % 9 == 7) begin
                    which = 0;
                end
                write_regs(step, npts, which);

                for (k = 0; k < n_eff; k++) begin
                    send_beat(beg_pkg::OP_LOAD, 4'(k), pt_time[k], pt_level[k]);
                end
                send_beat(beg_pkg::OP_RESTART, 4'($urandom), $urandom, $urandom);
                for (k = 0; k < ticks; k++) begin
                    if (phase == 5 && k == ticks / 2) begin
                        wait_results();
                    end
                    r = $urandom_range(0, 24);
                    case (r)
                        0: send_beat(beg_pkg::OP_NONE, 4'($urandom), $urandom, $urandom);
                        1: send_beat(beg_pkg::OP_RESTART, 4'($urandom), $urandom, $urandom);
                        2: send_beat(beg_pkg::OP_LOAD, 4'($urandom), $urandom, $urandom);
                        default: send_beat(beg_pkg::OP_TICK, 4'($urandom), $urandom, $urandom);
                    endcase
                end
            end else begin
                // noise: random ops over random, mostly unordered, tables
                write_regs($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0010_0000),
                           npts, 0);
                for (k = 0; k < 24; k++) begin
                    send_beat(beg_pkg::t_op'(2'($urandom_range(0, 3))), 4'($urandom),
                              $urandom, $urandom);
                end
            end
        end

        wait_results();
        repeat (20) @(posedge i_clk);
        $display("tb: %0d input beats, %0d results compared, %0d of them past the last breakpoint",
                 beats_sent, checked, done_seen);
        $display("tb: %0d register writes over %0d table phases, zero/unit/full-scale steps",
                 reg_writes, phase);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
